@@ rtl/kvlt_pkg.sv @@
// Shared types and constants of the key/value line tokenizer.
// Used by the channel interfaces and the top level; depends on nothing.
package kvlt_pkg;

    // Widths of the word fields on both channels.
    localparam int CH_BITS        = 8;
    localparam int OFFSET_OUT     = 16;
    localparam int KEY_LEN_BITS   = 8;
    localparam int VAL_LEN_BITS   = 10;

    // Configuration port.
    localparam int CFG_DATA_BITS  = 11;
    localparam int KEY_CAP_BITS   = 9;
    localparam int VAL_CAP_BITS   = 11;

    typedef enum logic [0:0] {
        CFG_KEY_CAPACITY   = 1'b0,
        CFG_VALUE_CAPACITY = 1'b1
    } cfg_index_t;

    localparam logic [KEY_CAP_BITS-1:0] KEY_CAP_RESET = 9'd64;
    localparam logic [VAL_CAP_BITS-1:0] VAL_CAP_RESET = 11'd256;

    // Characters with a meaning to the scanner.
    localparam logic [CH_BITS-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CH_BITS-1:0] CHAR_TAB    = 8'h09;
    localparam logic [CH_BITS-1:0] CHAR_LF     = 8'h0A;
    localparam logic [CH_BITS-1:0] CHAR_CR     = 8'h0D;
    localparam logic [CH_BITS-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CH_BITS-1:0] CHAR_HASH   = 8'h23;
    localparam logic [CH_BITS-1:0] CHAR_SEMI   = 8'h3B;
    localparam logic [CH_BITS-1:0] CHAR_EQUALS = 8'h3D;

endpackage

@@ rtl/kvlt_byte_if.sv @@
// Text byte channel: valid/ready handshake carrying one byte per word.
// Depends on kvlt_pkg for field widths.
interface kvlt_byte_if;
    logic                          valid;
    logic                          ready;
    logic [kvlt_pkg::CH_BITS-1:0]  ch;
    logic                          last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

@@ rtl/kvlt_rec_if.sv @@
// Record channel: valid/ready handshake carrying one key/value record per word.
// Depends on kvlt_pkg for field widths.
interface kvlt_rec_if;
    logic                               valid;
    logic                               ready;
    logic [kvlt_pkg::OFFSET_OUT-1:0]    key_offset;
    logic [kvlt_pkg::KEY_LEN_BITS-1:0]  key_length;
    logic [kvlt_pkg::OFFSET_OUT-1:0]    value_offset;
    logic [kvlt_pkg::VAL_LEN_BITS-1:0]  value_length;
    logic                               offset_overflow;

    modport source (output valid, output key_offset, output key_length,
                    output value_offset, output value_length,
                    output offset_overflow, input ready);
    modport sink   (input valid, input key_offset, input key_length,
                    input value_offset, input value_length,
                    input offset_overflow, output ready);
endinterface

@@ rtl/key_value_line_tokenizer.sv @@
// Top level of the key/value line tokenizer: scans text bytes and emits records.
// Depends on kvlt_pkg, kvlt_byte_if and kvlt_rec_if.
//
//  Channel   Dir   Word contents
//  text      in    ch (8), last (1)
//  record    out   key_offset (16), key_length (8), value_offset (16),
//                  value_length (10), offset_overflow (1)
//  cfg_*     in    cfg_we, cfg_index (1), cfg_data (11), write only
//
// One byte is accepted per cycle. A line end that yields a record passes the
// snapshot and output registers: the line tracker registers a snapshot, then
// the length and cap stage fills the output register. Reset clears all scan
// state and loads the capacities 64 and 256. A stalled record holds the output
// register and, once the snapshot stage is full too, text.ready drops.
module key_value_line_tokenizer #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    kvlt_byte_if.sink                           text,
    kvlt_rec_if.source                          record,
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_index,
    input  logic [kvlt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int WIDE_BITS = (OFFSET_BITS + 1 > kvlt_pkg::OFFSET_OUT) ?
                               OFFSET_BITS + 1 : kvlt_pkg::OFFSET_OUT;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [WIDE_BITS-1:0]   KEY_FIELD_MAX = WIDE_BITS'(255);
    localparam logic [WIDE_BITS-1:0]   VAL_FIELD_MAX = WIDE_BITS'(1023);

    typedef logic [OFFSET_BITS-1:0] pos_t;

    // Line state handed from the tracker to the length stage at a line end.
    typedef struct packed {
        pos_t line_start;
        pos_t equals_position;
        pos_t key_last;
        pos_t value_first;
        logic value_started;
        pos_t line_last;
        logic overflow;
    } snap_t;

    // Configuration registers.
    logic [kvlt_pkg::KEY_CAP_BITS-1:0] key_cap_reg;
    logic [kvlt_pkg::VAL_CAP_BITS-1:0] val_cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cap_reg <= kvlt_pkg::KEY_CAP_RESET;
            val_cap_reg <= kvlt_pkg::VAL_CAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (kvlt_pkg::cfg_index_t'(cfg_index))
                kvlt_pkg::CFG_KEY_CAPACITY:
                    key_cap_reg <= cfg_data[kvlt_pkg::KEY_CAP_BITS-1:0];
                kvlt_pkg::CFG_VALUE_CAPACITY:
                    val_cap_reg <= cfg_data;
                default:
                    key_cap_reg <= key_cap_reg;
            endcase
        end
    end

    // Scan state.
    pos_t pos_reg, pos_next;
    logic overflow_reg, overflow_next;
    logic in_line_reg, in_line_next;
    pos_t line_start_reg, line_start_next;
    logic comment_reg, comment_next;
    logic eq_seen_reg, eq_seen_next;
    pos_t eq_pos_reg, eq_pos_next;
    pos_t key_last_reg, key_last_next;
    pos_t val_first_reg, val_first_next;
    logic val_started_reg, val_started_next;
    pos_t line_last_reg, line_last_next;

    logic  accept;
    logic  is_zero, is_lf, is_blank, line_open, line_end, candidate;
    logic  s1_valid_reg, s1_valid_next;
    snap_t s1_reg;
    logic  out_en;

    assign accept = text.valid && text.ready;

    // Byte classification.
    always_comb
    begin
        is_zero  = (text.ch == kvlt_pkg::CHAR_NUL);
        is_lf    = (text.ch == kvlt_pkg::CHAR_LF);
        is_blank = (text.ch == kvlt_pkg::CHAR_SPACE) || (text.ch == kvlt_pkg::CHAR_TAB) ||
                   (text.ch == kvlt_pkg::CHAR_CR) || is_lf;
    end

    // Line tracker: next values of the scan state for the byte at the input.
    always_comb
    begin
        line_start_next  = line_start_reg;
        comment_next     = comment_reg;
        eq_seen_next     = eq_seen_reg;
        eq_pos_next      = eq_pos_reg;
        key_last_next    = key_last_reg;
        val_first_next   = val_first_reg;
        val_started_next = val_started_reg;
        line_last_next   = line_last_reg;
        line_open        = in_line_reg;

        if (!is_zero && !is_lf)
        begin
            // The first non-blank byte opens a line.
            if (!in_line_reg && !is_blank)
            begin
                line_open        = 1'b1;
                line_start_next  = pos_reg;
                comment_next     = (text.ch == kvlt_pkg::CHAR_HASH) ||
                                   (text.ch == kvlt_pkg::CHAR_SEMI);
                eq_seen_next     = 1'b0;
                val_started_next = 1'b0;
                eq_pos_next      = '0;
                key_last_next    = pos_reg;
                val_first_next   = '0;
                line_last_next   = pos_reg;
            end
            if (line_open)
            begin
                priority if (!eq_seen_next)
                begin
                    if (text.ch == kvlt_pkg::CHAR_EQUALS)
                    begin
                        eq_seen_next = 1'b1;
                        eq_pos_next  = pos_reg;
                    end
                    else if (!is_blank)
                    begin
                        key_last_next = pos_reg;
                    end
                end
                else if (!val_started_next && !is_blank)
                begin
                    val_started_next = 1'b1;
                    val_first_next   = pos_reg;
                end
                if (!is_blank)
                begin
                    line_last_next = pos_reg;
                end
            end
        end

        line_end     = line_open && (is_zero || is_lf || text.last);
        in_line_next = line_open && !line_end;
        candidate    = line_end && !comment_next && eq_seen_next;
    end

    // Position counter: saturates with a sticky flag, a zero byte restarts it.
    always_comb
    begin
        priority if (is_zero)
        begin
            pos_next      = '0;
            overflow_next = 1'b0;
        end
        else if (pos_reg == POS_MAX)
        begin
            pos_next      = POS_MAX;
            overflow_next = 1'b1;
        end
        else
        begin
            pos_next      = pos_reg + 1'b1;
            overflow_next = overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            overflow_reg    <= 1'b0;
            in_line_reg     <= 1'b0;
            line_start_reg  <= '0;
            comment_reg     <= 1'b0;
            eq_seen_reg     <= 1'b0;
            eq_pos_reg      <= '0;
            key_last_reg    <= '0;
            val_first_reg   <= '0;
            val_started_reg <= 1'b0;
            line_last_reg   <= '0;
        end
        else if (accept)
        begin
            pos_reg         <= pos_next;
            overflow_reg    <= overflow_next;
            in_line_reg     <= in_line_next;
            line_start_reg  <= line_start_next;
            comment_reg     <= comment_next;
            eq_seen_reg     <= eq_seen_next;
            eq_pos_reg      <= eq_pos_next;
            key_last_reg    <= key_last_next;
            val_first_reg   <= val_first_next;
            val_started_reg <= val_started_next;
            line_last_reg   <= line_last_next;
        end
    end

    // Snapshot stage: holds a finished line that may yield a record.
    assign text.ready    = !s1_valid_reg || out_en;
    assign s1_valid_next = accept && candidate;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && s1_valid_next)
        begin
            s1_reg.line_start      <= line_start_next;
            s1_reg.equals_position <= eq_pos_next;
            s1_reg.key_last        <= key_last_next;
            s1_reg.value_first     <= val_first_next;
            s1_reg.value_started   <= val_started_next;
            s1_reg.line_last       <= line_last_next;
            s1_reg.overflow        <= overflow_reg;
        end
    end

    // Length stage: trimmed lengths, capacity caps and the value offset.
    logic [WIDE_BITS-1:0]                  klen_raw, vlen_raw, voff_wide;
    logic [kvlt_pkg::KEY_CAP_BITS-1:0]     key_lim, key_sat, key_fin;
    logic [kvlt_pkg::VAL_CAP_BITS-1:0]     val_lim, val_sat, val_fin;
    logic                                  emit;

    always_comb
    begin
        if (s1_reg.equals_position > s1_reg.line_start)
        begin
            klen_raw = WIDE_BITS'(s1_reg.key_last) - WIDE_BITS'(s1_reg.line_start) +
                       WIDE_BITS'(1);
        end
        else
        begin
            klen_raw = '0;
        end

        if (s1_reg.value_started)
        begin
            voff_wide = WIDE_BITS'(s1_reg.value_first);
            if (s1_reg.line_last >= s1_reg.value_first)
            begin
                vlen_raw = WIDE_BITS'(s1_reg.line_last) - WIDE_BITS'(s1_reg.value_first) +
                           WIDE_BITS'(1);
            end
            else
            begin
                vlen_raw = '0;
            end
        end
        else
        begin
            voff_wide = WIDE_BITS'(s1_reg.equals_position) + WIDE_BITS'(1);
            vlen_raw  = '0;
        end

        key_lim = (key_cap_reg == '0) ? '0 : key_cap_reg - 1'b1;
        val_lim = (val_cap_reg == '0) ? '0 : val_cap_reg - 1'b1;
        key_sat = (klen_raw > KEY_FIELD_MAX) ? kvlt_pkg::KEY_CAP_BITS'(255) :
                  klen_raw[kvlt_pkg::KEY_CAP_BITS-1:0];
        val_sat = (vlen_raw > VAL_FIELD_MAX) ? kvlt_pkg::VAL_CAP_BITS'(1023) :
                  vlen_raw[kvlt_pkg::VAL_CAP_BITS-1:0];
        key_fin = (key_sat > key_lim) ? key_lim : key_sat;
        val_fin = (val_sat > val_lim) ? val_lim : val_sat;
        emit    = s1_valid_reg && (key_fin != '0);
    end

    // Output register.
    logic                                 out_valid_reg;
    logic [kvlt_pkg::OFFSET_OUT-1:0]      key_off_reg, val_off_reg;
    logic [kvlt_pkg::KEY_LEN_BITS-1:0]    key_len_reg;
    logic [kvlt_pkg::VAL_LEN_BITS-1:0]    val_len_reg;
    logic                                 ovf_reg;

    assign out_en = !out_valid_reg || record.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && emit)
        begin
            key_off_reg <= kvlt_pkg::OFFSET_OUT'(WIDE_BITS'(s1_reg.line_start));
            key_len_reg <= key_fin[kvlt_pkg::KEY_LEN_BITS-1:0];
            val_off_reg <= voff_wide[kvlt_pkg::OFFSET_OUT-1:0];
            val_len_reg <= val_fin[kvlt_pkg::VAL_LEN_BITS-1:0];
            ovf_reg     <= s1_reg.overflow;
        end
    end

    assign record.valid           = out_valid_reg;
    assign record.key_offset      = key_off_reg;
    assign record.key_length      = key_len_reg;
    assign record.value_offset    = val_off_reg;
    assign record.value_length    = val_len_reg;
    assign record.offset_overflow = ovf_reg;

    // A shown record always has a key, and that key fits its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        record.valid |-> (record.key_length != '0))
        else $error("record with empty key");

    assert property (@(posedge clk) disable iff (!rst_n)
        record.valid |-> (kvlt_pkg::KEY_CAP_BITS'(record.key_length) < key_cap_reg))
        else $error("key length beyond capacity");

    // The overflow flag is only set while the counter sits at its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (pos_reg == POS_MAX))
        else $error("overflow flag without saturated position");

    // A zero byte restarts the counter and clears the flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_zero) |=> (pos_reg == '0) && !overflow_reg && !in_line_reg)
        else $error("zero byte did not restart the scan");

    // Input only stalls when the snapshot stage and the output register are full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !text.ready |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

endmodule
